/* hw/rtl/assert_macros.svh */
// Assertion helpers for the serializer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and synchronous reset.
`define LSSER_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check on the block clock and reset.
`define LSSER_ASSERT(label, prop, msg) \
   `LSSER_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

/* hw/rtl/lsser_pkg.sv */
`default_nettype none

package lsser_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int BIT_LEN_W  = 10;
   localparam int LATCH_W    = 16;
   localparam int WORD_W     = 32;
   localparam int INDEX_W    = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH     = 3'd4;

   // item kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // reset values of the timing registers
   localparam logic [BIT_LEN_W-1:0] RST_ONE_HIGH  = 10'd140;
   localparam logic [BIT_LEN_W-1:0] RST_ONE_LOW   = 10'd160;
   localparam logic [BIT_LEN_W-1:0] RST_ZERO_HIGH = 10'd70;
   localparam logic [BIT_LEN_W-1:0] RST_ZERO_LOW  = 10'd120;
   localparam logic [LATCH_W-1:0]   RST_LATCH     = 16'd12000;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_HIGH,
      PH_LOW,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic [BIT_LEN_W-1:0] one_high;
      logic [BIT_LEN_W-1:0] one_low;
      logic [BIT_LEN_W-1:0] zero_high;
      logic [BIT_LEN_W-1:0] zero_low;
      logic [LATCH_W-1:0]   latch;
   } timing_type;

   typedef struct packed {
      logic pin;
      logic done;
   } seq_out_type;

endpackage

`default_nettype wire

/* hw/rtl/led_strip_one_wire_serializer.sv */
`default_nettype none

// Channel   Dir  Handshake            Payload
// req_      in   tvalid/tready        tuser = kind, tdata = led_index, colour_word
// rsp_      out  tvalid/tready/tlast  tdata = line_level, tlast = frame_done
// csr_      in   we (no wait)         index, wdata = timing register value
//
// One word in, one word out, one word per cycle sustained unless rsp_ stalls:
// the phase and counter update is a single pass of logic between state and
// result register. Reset is synchronous; it restores the timing registers,
// clears all colour words and starts a frame at its leading low period.
// No clearing pass. A single result register parts the two sides: req_tready
// stays high while that register is empty or being drained, so a stalled
// rsp_ side holds one word and stops input only while it waits.
module led_strip_one_wire_serializer #(
   parameter int NUM_LEDS     = 8,
   parameter int BITS_PER_LED = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request words
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [39:0]                       req_tdata,  // [2:0] led_index, [34:3] colour_word, zero fill
   input  wire logic                              req_tuser,  // [0] kind
   // response words
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [7:0]                        rsp_tdata,  // [0] line_level, zero fill
   output      logic                              rsp_tlast,
   // timing registers
   input  wire logic                              csr_we,
   input  wire logic [lsser_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lsser_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int BIT_W = $clog2(BITS_PER_LED);

   lsser_pkg::timing_type  timing;
   lsser_pkg::seq_out_type seq_out;

   logic                              accept;
   logic                              tick;
   logic                              write_item;
   logic [lsser_pkg::INDEX_W-1:0]     req_led_index;
   logic [lsser_pkg::WORD_W-1:0]      req_colour_word;
   logic [LED_W-1:0]                  rd_led;
   logic [BIT_W-1:0]                  rd_bit;
   logic                              rd_value;

   logic rsp_valid_ff, rsp_valid_in;
   logic pin_ff, pin_in;
   logic done_ff, done_in;

   // unpack the request word
   assign req_led_index   = req_tdata[lsser_pkg::INDEX_W-1:0];
   assign req_colour_word = req_tdata[lsser_pkg::INDEX_W +: lsser_pkg::WORD_W];

   // accept whenever the result register frees up in this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign tick       = accept && (req_tuser == lsser_pkg::KIND_TICK);
   assign write_item = accept && (req_tuser == lsser_pkg::KIND_WRITE);

   lsser_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   lsser_store #(
      .NUM_LEDS     (NUM_LEDS),
      .BITS_PER_LED (BITS_PER_LED),
      .LED_W        (LED_W),
      .BIT_W        (BIT_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (write_item),
      .wr_index (req_led_index),
      .wr_word  (req_colour_word),
      .rd_led   (rd_led),
      .rd_bit   (rd_bit),
      .rd_value (rd_value)
   );

   lsser_seq #(
      .NUM_LEDS     (NUM_LEDS),
      .BITS_PER_LED (BITS_PER_LED),
      .LED_W        (LED_W),
      .BIT_W        (BIT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .write_item (write_item),
      .timing     (timing),
      .rd_led     (rd_led),
      .rd_bit     (rd_bit),
      .rd_value   (rd_value),
      .seq_out    (seq_out)
   );

   // result register: load on accept, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pin_in       = pin_ff;
      done_in      = done_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         pin_in       = seq_out.pin;
         done_in      = seq_out.done;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pin_ff  <= pin_in;
      done_ff <= done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, pin_ff};
   assign rsp_tlast  = done_ff;

endmodule

`default_nettype wire

/* hw/rtl/lsser_cfg.sv */
`default_nettype none

module lsser_cfg (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [lsser_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lsser_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output      lsser_pkg::timing_type              timing
);

   lsser_pkg::timing_type timing_ff;
   lsser_pkg::timing_type timing_in;

   always_comb begin
      timing_in = timing_ff;
      if (csr_we) begin
         unique case (csr_index)
            lsser_pkg::CSR_ONE_HIGH:
               timing_in.one_high = csr_wdata[lsser_pkg::BIT_LEN_W-1:0];
            lsser_pkg::CSR_ONE_LOW:
               timing_in.one_low = csr_wdata[lsser_pkg::BIT_LEN_W-1:0];
            lsser_pkg::CSR_ZERO_HIGH:
               timing_in.zero_high = csr_wdata[lsser_pkg::BIT_LEN_W-1:0];
            lsser_pkg::CSR_ZERO_LOW:
               timing_in.zero_low = csr_wdata[lsser_pkg::BIT_LEN_W-1:0];
            lsser_pkg::CSR_LATCH:
               timing_in.latch = csr_wdata[lsser_pkg::LATCH_W-1:0];
            default: ; // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.one_high  <= lsser_pkg::RST_ONE_HIGH;
         timing_ff.one_low   <= lsser_pkg::RST_ONE_LOW;
         timing_ff.zero_high <= lsser_pkg::RST_ZERO_HIGH;
         timing_ff.zero_low  <= lsser_pkg::RST_ZERO_LOW;
         timing_ff.latch     <= lsser_pkg::RST_LATCH;
      end else begin
         timing_ff <= timing_in;
      end
   end

   assign timing = timing_ff;

endmodule

`default_nettype wire

/* hw/rtl/lsser_store.sv */
`default_nettype none

module lsser_store #(
   parameter int NUM_LEDS     = 8,
   parameter int BITS_PER_LED = 32,
   parameter int LED_W        = 3,
   parameter int BIT_W        = 5
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              wr_en,
   input  wire logic [lsser_pkg::INDEX_W-1:0]     wr_index,
   input  wire logic [lsser_pkg::WORD_W-1:0]      wr_word,
   input  wire logic [LED_W-1:0]                  rd_led,
   input  wire logic [BIT_W-1:0]                  rd_bit,
   output      logic                              rd_value
);

   logic [BITS_PER_LED-1:0] led_words_ff [NUM_LEDS];
   logic [BITS_PER_LED-1:0] rd_word;

   // indexes beyond the store match no entry and are dropped
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
         if (reset) begin
            led_words_ff[i] <= '0;
         end else if (wr_en && (int'(wr_index) == i)) begin
            led_words_ff[i] <= wr_word[BITS_PER_LED-1:0];
         end
      end
   end

   assign rd_word  = led_words_ff[rd_led];
   assign rd_value = rd_word[rd_bit];

endmodule

`default_nettype wire

/* hw/rtl/lsser_seq.sv */
`default_nettype none

`include "assert_macros.svh"

module lsser_seq #(
   parameter int NUM_LEDS     = 8,
   parameter int BITS_PER_LED = 32,
   parameter int LED_W        = 3,
   parameter int BIT_W        = 5
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     tick,
   input  wire logic                     write_item,
   input  wire lsser_pkg::timing_type    timing,
   output      logic [LED_W-1:0]         rd_led,
   output      logic [BIT_W-1:0]         rd_bit,
   input  wire logic                     rd_value,
   output      lsser_pkg::seq_out_type   seq_out
);

   localparam logic [LED_W-1:0] LAST_LED = LED_W'(NUM_LEDS - 1);
   localparam logic [BIT_W-1:0] BIT_TOP  = BIT_W'(BITS_PER_LED - 1);
   localparam int               LEN_W    = lsser_pkg::LATCH_W;

   lsser_pkg::phase_type phase_ff, phase_in;
   logic [LED_W-1:0]     led_ff, led_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [LEN_W-1:0]     tick_ff, tick_in;
   logic                 cur_bit_ff, cur_bit_in;

   logic [LEN_W-1:0]     seg_len;
   logic [LEN_W:0]       tick_next;
   logic                 seg_end;
   logic                 advance;
   logic                 more_bits;

   // length of the segment the pin is in
   always_comb begin
      case (phase_ff)
         lsser_pkg::PH_HIGH:
            seg_len = cur_bit_ff ? LEN_W'(timing.one_high) : LEN_W'(timing.zero_high);
         lsser_pkg::PH_LOW:
            seg_len = cur_bit_ff ? LEN_W'(timing.one_low) : LEN_W'(timing.zero_low);
         default:
            seg_len = timing.latch;
      endcase
   end

   // a zero length ends on the first tick as well
   assign tick_next = {1'b0, tick_ff} + (LEN_W+1)'(1);
   assign seg_end   = (tick_next >= {1'b0, seg_len});
   assign advance   = tick && seg_end;
   assign more_bits = (bit_ff != '0) || (led_ff != LAST_LED);

   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (phase_ff)
            lsser_pkg::PH_LEAD:  phase_in = lsser_pkg::PH_HIGH;
            lsser_pkg::PH_HIGH:  phase_in = lsser_pkg::PH_LOW;
            lsser_pkg::PH_LOW:   phase_in = more_bits ? lsser_pkg::PH_HIGH
                                                      : lsser_pkg::PH_TRAIL;
            lsser_pkg::PH_TRAIL: phase_in = lsser_pkg::PH_LEAD;
            default:             phase_in = lsser_pkg::PH_LEAD;
         endcase
      end
   end

   always_comb begin
      led_in       = led_ff;
      bit_in       = bit_ff;
      tick_in      = tick_ff;
      seq_out.pin  = (phase_ff == lsser_pkg::PH_HIGH);
      seq_out.done = 1'b0;
      if (tick) begin
         tick_in = seg_end ? '0 : tick_next[LEN_W-1:0];
      end
      if (advance) begin
         unique case (phase_ff)
            lsser_pkg::PH_LEAD: begin
               led_in = '0;
               bit_in = BIT_TOP;
            end
            lsser_pkg::PH_HIGH: ;
            lsser_pkg::PH_LOW: begin
               if (bit_ff != '0) begin
                  bit_in = bit_ff - BIT_W'(1);
               end else if (led_ff != LAST_LED) begin
                  led_in = led_ff + LED_W'(1);
                  bit_in = BIT_TOP;
               end
            end
            lsser_pkg::PH_TRAIL: begin
               led_in       = '0;
               bit_in       = BIT_TOP;
               seq_out.done = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // take the bit from the store as its high pulse starts
   assign rd_led     = led_in;
   assign rd_bit     = bit_in;
   assign cur_bit_in = (advance && (phase_in == lsser_pkg::PH_HIGH)) ? rd_value : cur_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lsser_pkg::PH_LEAD;
         led_ff     <= '0;
         bit_ff     <= BIT_TOP;
         tick_ff    <= '0;
         cur_bit_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         led_ff     <= led_in;
         bit_ff     <= bit_in;
         tick_ff    <= tick_in;
         cur_bit_ff <= cur_bit_in;
      end
   end

   `LSSER_ASSERT(a_frame_wrap,
      (tick && seg_end && (phase_ff == lsser_pkg::PH_TRAIL))
         |=> ((phase_ff == lsser_pkg::PH_LEAD) && (led_ff == '0) && (bit_ff == BIT_TOP)),
      "frame end did not rewind counters")
   `LSSER_ASSERT(a_write_holds,
      (write_item && !tick) |=> ($stable(phase_ff) && $stable(tick_ff) && $stable(cur_bit_ff)),
      "write word moved the waveform")
   `LSSER_ASSERT(a_phase_clears_tick,
      (phase_ff != $past(phase_ff)) |-> (tick_ff == '0),
      "segment started with a stale tick count")

endmodule

`default_nettype wire
